>>> src/civdt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and month tables for the civil date-time to epoch converter.
// No dependencies.

package civdt_pkg;

  // Year bias: a whole number of 400-year eras, so the biased year is never negative
  localparam int unsigned ERA_BIAS   = 82;
  localparam int unsigned YEAR_BIAS  = ERA_BIAS * 400;

  // Reciprocal of 400, exact for every biased year below 2^17
  localparam int unsigned ERA_SHIFT  = 26;
  localparam int unsigned ERA_RECIP  = ((1 << ERA_SHIFT) + 399) / 400;

  localparam int unsigned DAYS_PER_ERA   = 146097;
  // Day number of 1970-01-01 counted from 0000-03-01, plus one for the day-of-month base
  localparam int unsigned EPOCH_DAY_BIAS = 719468 + 1;
  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_HOUR  = 3600;

  localparam int          MAX_OFFSET_MIN = 14 * 60;
  localparam int unsigned MAX_HOUR       = 23;
  localparam int unsigned MAX_MINUTE     = 59;
  localparam int unsigned MAX_SECOND     = 59;
  localparam int unsigned MAX_MILLI      = 999;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic signed [15:0] YEAR_INVALID = 16'sh8000;

  // Days from 1 March to the first of the given month (March-based year)
  function automatic logic [8:0] march_offset(input logic [3:0] month);
    logic [8:0] res;
    unique case (month)
      4'd3:    res = 9'd0;
      4'd4:    res = 9'd31;
      4'd5:    res = 9'd61;
      4'd6:    res = 9'd92;
      4'd7:    res = 9'd122;
      4'd8:    res = 9'd153;
      4'd9:    res = 9'd184;
      4'd10:   res = 9'd214;
      4'd11:   res = 9'd245;
      4'd12:   res = 9'd275;
      4'd1:    res = 9'd306;
      4'd2:    res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Length of the given month; leap only matters for February
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] res;
    unique case (month)
      4'd2:                      res = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   res = 5'd30;
      default:                   res = 5'd31;
    endcase
    return res;
  endfunction

endpackage

>>> src/civil_datetime_to_epoch_core.sv
`timescale 1ns / 1ps
// Civil date-time to UTC epoch seconds, five-register pipeline.
// Depends on civdt_pkg.
//
// out_valid rises once a request has passed the input register, stages 1 to 3 and the result register.
// Throughput: one request per cycle; busy is held low, the pipeline never stalls.
// Depth is set by the multiplier stages (era reciprocal, era day base, day-to-seconds) and
// the era/day-count adds between them. The receiver cannot stall the results.
// Reset (rst_n low, synchronous) drops every request in flight; out_valid is low after it.

module civil_datetime_to_epoch_core import civdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_year_value,
  input  logic        [3:0]  in_month_value,
  input  logic        [4:0]  in_day_value,
  input  logic        [4:0]  in_hour_value,
  input  logic        [5:0]  in_minute_value,
  input  logic        [5:0]  in_second_value,
  input  logic        [9:0]  in_milli_value,
  input  logic signed [11:0] in_offset_minutes,
  output logic               out_valid,
  output logic               out_is_valid,
  output logic signed [41:0] out_epoch_seconds,
  output logic        [9:0]  out_epoch_millis
);

  // Stage 0: input register
  logic               v0_r;
  logic signed [15:0] year0_r;
  logic        [3:0]  month0_r;
  logic        [4:0]  day0_r;
  logic        [4:0]  hour0_r;
  logic        [5:0]  min0_r;
  logic        [5:0]  sec0_r;
  logic        [9:0]  milli0_r;
  logic signed [11:0] offs0_r;

  // Stage 1: biased year and its era
  logic               v1_r;
  logic        [16:0] yy1_r,   yy1_nxt;
  logic        [7:0]  erau1_r, erau1_nxt;
  logic        [3:0]  month1_r;
  logic        [4:0]  day1_r;
  logic signed [19:0] tod1_r,  tod1_nxt;
  logic        [9:0]  milli1_r;
  logic               ok1_r,   ok1_nxt;
  logic               mok1_r,  mok1_nxt;

  // Stage 2: year of era and era day base
  logic               v2_r;
  logic        [8:0]  yoe2_r,  yoe2_nxt;
  logic signed [25:0] erad2_r, erad2_nxt;
  logic        [3:0]  month2_r;
  logic        [4:0]  day2_r;
  logic signed [19:0] tod2_r;
  logic        [9:0]  milli2_r;
  logic               ok2_r,   ok2_nxt;
  logic               mok2_r;

  // Stage 3: days since the epoch
  logic               v3_r;
  logic signed [25:0] days3_r, days3_nxt;
  logic signed [19:0] tod3_r;
  logic        [9:0]  milli3_r;
  logic               ok3_r;
  logic               mok3_r;

  // Result register
  logic               out_valid_r;
  logic               out_ok_r;
  logic signed [41:0] out_secs_r, out_secs_nxt;
  logic        [9:0]  out_milli_r;

  logic               accept;

  // Intermediate terms
  logic signed [17:0] yy_full;
  logic        [34:0] era_prod;
  logic        [16:0] tod_pos;
  logic signed [19:0] offs_sec;
  logic        [16:0] yoe_full;
  logic signed [8:0]  era;
  logic        [9:0]  yoe_p1;
  logic               leap;
  logic        [1:0]  cent;
  logic        [17:0] doe;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Sign-extend the year for the bias add
  function automatic logic signed [17:0] in_year_sx(input logic signed [15:0] y);
    return 18'(y);
  endfunction

  // Stage 1: bias the year (March-based), divide by 400, fold the time of day, check the field ranges
  always_comb begin
    yy_full   = 18'(in_year_sx(year0_r)) + 18'sd0 + $signed(18'(YEAR_BIAS))
              - ((month0_r <= MONTH_FEB) ? 18'sd1 : 18'sd0);
    yy1_nxt   = yy_full[16:0];
    era_prod  = {18'b0, yy1_nxt} * 35'(ERA_RECIP);
    erau1_nxt = era_prod[33:26];

    tod_pos   = 17'(hour0_r) * 17'(SECS_PER_HOUR) + 17'(min0_r) * 17'd60 + 17'(sec0_r);
    offs_sec  = 20'(offs0_r) * 20'sd60;
    tod1_nxt  = $signed({3'b0, tod_pos}) - offs_sec;

    mok1_nxt  = (month0_r >= MONTH_JAN) && (month0_r <= MONTH_DEC);
    ok1_nxt   = mok1_nxt
              && (day0_r != 5'd0)
              && (hour0_r <= 5'(MAX_HOUR))
              && (min0_r <= 6'(MAX_MINUTE))
              && (sec0_r <= 6'(MAX_SECOND))
              && (milli0_r <= 10'(MAX_MILLI))
              && (offs0_r >= -12'(MAX_OFFSET_MIN))
              && (offs0_r <= 12'(MAX_OFFSET_MIN))
              && (year0_r != YEAR_INVALID);
  end

  // Stage 2: year of era, era day base, leap rule and day-in-month check
  always_comb begin
    yoe_full  = yy1_r - 17'({9'b0, erau1_r} * 17'd400);
    yoe2_nxt  = yoe_full[8:0];
    era       = $signed({1'b0, erau1_r}) - $signed(9'(ERA_BIAS));
    erad2_nxt = 26'(era) * $signed(26'(DAYS_PER_ERA));

    // February is counted in the previous March-based year, so its year is yoe + 1
    yoe_p1    = {1'b0, yoe2_nxt} + 10'd1;
    leap      = (yoe_p1[1:0] == 2'b00)
              && (yoe_p1 != 10'd100) && (yoe_p1 != 10'd200) && (yoe_p1 != 10'd300);
    ok2_nxt   = ok1_r && (day1_r <= month_len(month1_r, leap));
  end

  // Stage 3: day of era and days since the epoch
  always_comb begin
    if (yoe2_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe2_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe2_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doe       = 18'(yoe2_r) * 18'd365 + 18'(yoe2_r[8:2]) - 18'(cent)
              + 18'(march_offset(month2_r)) + 18'(day2_r);
    days3_nxt = erad2_r + $signed({8'b0, doe}) - $signed(26'(EPOCH_DAY_BIAS));
  end

  // Stage 4: scale days to seconds; month out of range gives zero
  always_comb begin
    if (mok3_r) begin
      out_secs_nxt = 42'(days3_r) * $signed(42'(SECS_PER_DAY)) + 42'(tod3_r);
    end else begin
      out_secs_nxt = '0;
    end
  end

  // Advance the valid bits; reset drops everything in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= accept;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Advance the payload every cycle
  always_ff @(posedge clk) begin
    year0_r     <= in_year_value;
    month0_r    <= in_month_value;
    day0_r      <= in_day_value;
    hour0_r     <= in_hour_value;
    min0_r      <= in_minute_value;
    sec0_r      <= in_second_value;
    milli0_r    <= in_milli_value;
    offs0_r     <= in_offset_minutes;

    yy1_r       <= yy1_nxt;
    erau1_r     <= erau1_nxt;
    month1_r    <= month0_r;
    day1_r      <= day0_r;
    tod1_r      <= tod1_nxt;
    milli1_r    <= milli0_r;
    ok1_r       <= ok1_nxt;
    mok1_r      <= mok1_nxt;

    yoe2_r      <= yoe2_nxt;
    erad2_r     <= erad2_nxt;
    month2_r    <= month1_r;
    day2_r      <= day1_r;
    tod2_r      <= tod1_r;
    milli2_r    <= milli1_r;
    ok2_r       <= ok2_nxt;
    mok2_r      <= mok1_r;

    days3_r     <= days3_nxt;
    tod3_r      <= tod2_r;
    milli3_r    <= milli2_r;
    ok3_r       <= ok2_r;
    mok3_r      <= mok2_r;

    out_ok_r    <= ok3_r;
    out_secs_r  <= out_secs_nxt;
    out_milli_r <= milli3_r;
  end

  assign out_valid         = out_valid_r;
  assign out_is_valid      = out_ok_r;
  assign out_epoch_seconds = out_secs_r;
  assign out_epoch_millis  = out_milli_r;

  // Every accepted request passes stages 0 to 3 and reaches the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("request did not reach the result register on time");

  // A valid result never carries an out-of-range millisecond
  a_milli_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_valid) |-> (out_epoch_millis <= 10'(MAX_MILLI)))
    else $error("valid result with millisecond above range");

  // A request judged valid in the day check always has its month in range
  a_valid_month: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && ok2_r) |-> mok2_r)
    else $error("valid flag set with month out of range");

  // An out-of-range month yields a zero result at the next stage
  a_month_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !mok3_r) |=> (out_valid && !out_is_valid && (out_epoch_seconds == 42'sd0)))
    else $error("month out of range did not give zero seconds");

endmodule
